// File: hw/rtl/tlv_image_record_finder_unit_macros.svh
// Assertion macros for the TLV image record finder.
// Used by the port checker; needs clk and rst_n in the enclosing scope.
`ifndef TLV_IMAGE_RECORD_FINDER_UNIT_MACROS_SVH
`define TLV_IMAGE_RECORD_FINDER_UNIT_MACROS_SVH

// Same-cycle implication, switched off while in reset.
`define TLV_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, switched off while in reset.
`define TLV_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

// Next-cycle implication that also holds across reset.
`define TLV_ASSERT_RESET(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) else $error(msg);

`endif

// File: hw/rtl/tlv_irf_pkg.sv
// Shared types and constants for the TLV image record finder.
// No dependencies.
package tlv_irf_pkg;

  localparam logic        CMD_START  = 1'b0;
  localparam logic        CMD_BYTE   = 1'b1;
  localparam logic [1:0]  MODE_WHOLE = 2'd1;
  localparam logic [1:0]  MODE_LIST  = 2'd2;
  localparam logic [31:0] HDR_BYTES  = 32'd8;
  localparam logic [31:0] IMAGE_TYPE = 32'd1;
  localparam logic [2:0]  HDR_LAST   = 3'd7;

  typedef struct packed {
    logic        cmd;
    logic [1:0]  mode;
    logic [31:0] payload_len;
    logic [7:0]  data_byte;
  } item_t;

  typedef struct packed {
    logic        found;
    logic [31:0] image_offset;
    logic [31:0] image_length;
  } result_t;

endpackage

// File: hw/rtl/tlv_irf_scan.sv
// Record scanner: parse state and per-transaction next-state logic.
// Depends on tlv_irf_pkg.
module tlv_irf_scan (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 step,
  input  tlv_irf_pkg::item_t   item,
  output logic                 res_valid,
  output tlv_irf_pkg::result_t res
);

  typedef enum logic [1:0] {
    PH_DONE   = 2'd0,
    PH_HEADER = 2'd1,
    PH_SKIP   = 2'd2
  } phase_t;

  phase_t      phase_r, phase_nxt;
  logic [2:0]  hdr_idx_r, hdr_idx_nxt;
  logic [31:0] rec_type_r, rec_type_nxt;
  logic [31:0] rec_size_r, rec_size_nxt;
  logic [31:0] offset_r, offset_nxt;
  logic [31:0] remain_r, remain_nxt;
  logic [31:0] skip_r, skip_nxt;

  logic [31:0] size_full;
  logic [31:0] offset_inc;
  logic [31:0] remain_dec;
  logic [31:0] skip_dec;

  // remain_r tracks payload bytes not yet consumed, so no wide sum is needed
  assign offset_inc = offset_r + 32'd1;
  assign remain_dec = remain_r - 32'd1;
  assign size_full  = {item.data_byte, rec_size_r[23:0]};
  assign skip_dec   = (skip_r != 32'd0) ? skip_r - 32'd1 : skip_r;

  always_comb begin
    phase_nxt    = phase_r;
    hdr_idx_nxt  = hdr_idx_r;
    rec_type_nxt = rec_type_r;
    rec_size_nxt = rec_size_r;
    offset_nxt   = offset_r;
    remain_nxt   = remain_r;
    skip_nxt     = skip_r;
    res_valid    = 1'b0;
    res          = '0;
    if (step) begin
      if (item.cmd == tlv_irf_pkg::CMD_START) begin
        hdr_idx_nxt  = '0;
        rec_type_nxt = '0;
        rec_size_nxt = '0;
        offset_nxt   = '0;
        remain_nxt   = item.payload_len;
        skip_nxt     = '0;
        phase_nxt    = PH_DONE;
        priority if (item.mode == tlv_irf_pkg::MODE_WHOLE) begin
          res_valid        = 1'b1;
          res.found        = (item.payload_len != 32'd0);
          res.image_length = item.payload_len;
        end else if (item.mode == tlv_irf_pkg::MODE_LIST) begin
          if (item.payload_len < tlv_irf_pkg::HDR_BYTES) begin
            res_valid = 1'b1;
          end else begin
            phase_nxt = PH_HEADER;
          end
        end else begin
          res_valid = 1'b1;
        end
      end else begin
        unique case (phase_r)
          PH_HEADER: begin
            offset_nxt  = offset_inc;
            remain_nxt  = remain_dec;
            hdr_idx_nxt = hdr_idx_r + 3'd1;
            if (hdr_idx_r[2]) begin
              rec_size_nxt[{hdr_idx_r[1:0], 3'b000} +: 8] = item.data_byte;
            end else begin
              rec_type_nxt[{hdr_idx_r[1:0], 3'b000} +: 8] = item.data_byte;
            end
            if (hdr_idx_r == tlv_irf_pkg::HDR_LAST) begin
              priority if (size_full > remain_dec) begin
                // record overruns the payload
                res_valid = 1'b1;
                phase_nxt = PH_DONE;
              end else if (rec_type_r == tlv_irf_pkg::IMAGE_TYPE) begin
                res_valid        = 1'b1;
                res.found        = 1'b1;
                res.image_offset = offset_inc;
                res.image_length = size_full;
                phase_nxt        = PH_DONE;
              end else if (size_full == 32'd0) begin
                hdr_idx_nxt  = '0;
                rec_type_nxt = '0;
                rec_size_nxt = '0;
                if (remain_dec < tlv_irf_pkg::HDR_BYTES) begin
                  res_valid = 1'b1;
                  phase_nxt = PH_DONE;
                end
              end else begin
                skip_nxt  = size_full;
                phase_nxt = PH_SKIP;
              end
            end
          end
          PH_SKIP: begin
            offset_nxt = offset_inc;
            remain_nxt = remain_dec;
            skip_nxt   = skip_dec;
            if (skip_dec == 32'd0) begin
              hdr_idx_nxt  = '0;
              rec_type_nxt = '0;
              rec_size_nxt = '0;
              if (remain_dec < tlv_irf_pkg::HDR_BYTES) begin
                res_valid = 1'b1;
                phase_nxt = PH_DONE;
              end else begin
                phase_nxt = PH_HEADER;
              end
            end
          end
          default: begin
            // idle: bytes are dropped
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r    <= PH_DONE;
      hdr_idx_r  <= '0;
      rec_type_r <= '0;
      rec_size_r <= '0;
      offset_r   <= '0;
      remain_r   <= '0;
      skip_r     <= '0;
    end else begin
      phase_r    <= phase_nxt;
      hdr_idx_r  <= hdr_idx_nxt;
      rec_type_r <= rec_type_nxt;
      rec_size_r <= rec_size_nxt;
      offset_r   <= offset_nxt;
      remain_r   <= remain_nxt;
      skip_r     <= skip_nxt;
    end
  end

endmodule

// File: hw/rtl/tlv_image_record_finder_unit.sv
// TLV image record finder, top level.
//
// Input channel (in_*): one transaction per item. in_cmd = 0 starts a payload
// with in_mode and in_payload_len; in_cmd = 1 carries one payload byte in
// in_data_byte. Mode 1 answers at once with the whole payload as the image,
// mode 2 scans 8-byte little-endian headers (type, size) for the first type 1
// record that fits; other modes fail.
// Result channel (out_*): at most one transaction per payload, out_found with
// offset and length, both zero on failure. Bytes after the answer are dropped.
// The item that causes a result passes the input register, then the result
// register. Throughput: one item per cycle while no result is stalled;
// each byte needs a 32-bit increment, two decrements and a few compares.
// Reset (synchronous, rst_n low): scanner idle, both registers empty.
// When the receiver stalls, the result holds; one more item is held in the
// input register, then in_stall rises until the result is taken.
module tlv_image_record_finder_unit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_cmd,
  input  logic [1:0]  in_mode,
  input  logic [31:0] in_payload_len,
  input  logic [7:0]  in_data_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        out_found,
  output logic [31:0] out_image_offset,
  output logic [31:0] out_image_length
);

  tlv_irf_pkg::item_t   item_r;
  logic                 item_v_r;
  tlv_irf_pkg::result_t out_r;
  logic                 out_valid_r;
  tlv_irf_pkg::result_t res;
  logic                 res_valid;
  logic                 process;

  assign process  = item_v_r && (!out_valid_r || !out_stall);
  assign in_stall = item_v_r && !process;

  tlv_irf_scan u_scan (
    .clk       (clk),
    .rst_n     (rst_n),
    .step      (process),
    .item      (item_r),
    .res_valid (res_valid),
    .res       (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      item_v_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        item_v_r <= 1'b1;
      end else if (process) begin
        item_v_r <= 1'b0;
      end
      if (process && res_valid) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      item_r.cmd         <= in_cmd;
      item_r.mode        <= in_mode;
      item_r.payload_len <= in_payload_len;
      item_r.data_byte   <= in_data_byte;
    end
    if (process && res_valid) begin
      out_r <= res;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_found        = out_r.found;
  assign out_image_offset = out_r.image_offset;
  assign out_image_length = out_r.image_length;

endmodule

// File: hw/rtl/tlv_irf_checker.sv
// Port-level checker for the TLV image record finder, bound to the top level.
// Depends on tlv_image_record_finder_unit_macros.svh.
`include "tlv_image_record_finder_unit_macros.svh"

module tlv_irf_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic        out_found,
  input logic [31:0] out_image_offset,
  input logic [31:0] out_image_length
);

  // a stalled result holds
  `TLV_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_found) && $stable(out_image_offset) && $stable(out_image_length), "result changed under stall")

  // failures carry zero offset and length
  `TLV_ASSERT_NOW(a_fail_zero, out_valid && !out_found, out_image_offset == 32'd0 && out_image_length == 32'd0, "failure with nonzero fields")

  // input back-pressure only while a result is blocked
  `TLV_ASSERT_NOW(a_stall_cause, in_stall, out_valid && out_stall, "input stalled without blocked result")

  // reset empties the result register
  `TLV_ASSERT_RESET(a_reset_empty, !rst_n, !out_valid && !in_stall, "pipeline not empty after reset")

endmodule

bind tlv_image_record_finder_unit tlv_irf_checker u_tlv_irf_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .in_stall         (in_stall),
  .out_valid        (out_valid),
  .out_stall        (out_stall),
  .out_found        (out_found),
  .out_image_offset (out_image_offset),
  .out_image_length (out_image_length)
);
